[rtl/core/slrx_pkg.sv]
package slrx_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED    = 3'd4;

    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
    localparam logic [15:0] LENGTH_LIM_RESET  = 16'd256;
    localparam logic [15:0] CRC_POLY_RESET    = 16'h8005;
    localparam logic [15:0] CRC_SEED_RESET    = 16'hFFFF;
    localparam logic [15:0] CRC_FINAL_XOR     = 16'hFFFF;

    // event codes carried on m_tuser
    localparam logic [1:0] EV_PAYLOAD   = 2'd0;
    localparam logic [1:0] EV_GOOD      = 2'd1;
    localparam logic [1:0] EV_CRC_BAD   = 2'd2;
    localparam logic [1:0] EV_LEN_LARGE = 2'd3;

    typedef enum logic [8:0] {
        PH_SYNC0   = 9'b0_0000_0001,
        PH_SYNC1   = 9'b0_0000_0010,
        PH_CMD     = 9'b0_0000_0100,
        PH_SEQ     = 9'b0_0000_1000,
        PH_LENH    = 9'b0_0001_0000,
        PH_LENL    = 9'b0_0010_0000,
        PH_PAYLOAD = 9'b0_0100_0000,
        PH_CRCH    = 9'b0_1000_0000,
        PH_CRCL    = 9'b1_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] length_limit;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_seed;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  command;
        logic [7:0]  sequence_res;
        logic [15:0] frame_length;
        logic [15:0] crc_received;
        logic [15:0] crc_computed;
    } res_t;

endpackage

[rtl/core/slrx_cfg_regs.sv]
module slrx_cfg_regs
    import slrx_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SYNC_FIRST:  cfg_next.sync_first     = cfg_wdata[7:0];
                CFG_SYNC_SECOND: cfg_next.sync_second    = cfg_wdata[7:0];
                CFG_LENGTH_LIM:  cfg_next.length_limit   = cfg_wdata;
                CFG_CRC_POLY:    cfg_next.crc_polynomial = cfg_wdata;
                CFG_CRC_SEED:    cfg_next.crc_seed       = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first     <= SYNC_FIRST_RESET;
            cfg_reg.sync_second    <= SYNC_SECOND_RESET;
            cfg_reg.length_limit   <= LENGTH_LIM_RESET;
            cfg_reg.crc_polynomial <= CRC_POLY_RESET;
            cfg_reg.crc_seed       <= CRC_SEED_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/slrx_crc8.sv]
module slrx_crc8
    import slrx_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    input  logic [15:0] polynomial,
    output logic [15:0] crc_out
);

    // reflected crc, eight lsb-first shift steps per byte
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ polynomial;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

[rtl/core/slrx_parser.sv]
module slrx_parser
    import slrx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       emit,
    output res_t       res
);

    phase_t      phase_reg,    phase_next;
    logic [7:0]  command_reg,  command_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [15:0] length_reg,   length_next;
    logic [15:0] count_reg,    count_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;

    logic [15:0] crc_in;
    logic [15:0] crc_upd;
    logic [15:0] count_inc;
    logic [15:0] crc_rx;
    logic [15:0] crc_calc;

    // a new frame restarts from the seed on the first sync byte
    assign crc_in = (phase_reg == PH_SYNC0) ? cfg.crc_seed : crc_reg;

    slrx_crc8 u_crc8 (
        .crc_in     (crc_in),
        .data_in    (rx_byte),
        .polynomial (cfg.crc_polynomial),
        .crc_out    (crc_upd)
    );

    assign count_inc = count_reg + 16'd1;
    assign crc_rx    = {crc_high_reg, rx_byte};
    assign crc_calc  = crc_reg ^ CRC_FINAL_XOR;

    always_comb begin
        phase_next    = phase_reg;
        command_next  = command_reg;
        sequence_next = sequence_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        emit          = 1'b0;
        res.event_res    = EV_PAYLOAD;
        res.data_byte    = 8'd0;
        res.byte_index   = 16'd0;
        res.crc_received = 16'd0;
        res.crc_computed = 16'd0;

        unique case (phase_reg)
            PH_SYNC1: begin
                if (rx_byte == cfg.sync_second) begin
                    crc_next   = crc_upd;
                    phase_next = PH_CMD;
                end else begin
                    phase_next = PH_SYNC0;
                end
            end
            PH_CMD: begin
                command_next = rx_byte;
                crc_next     = crc_upd;
                phase_next   = PH_SEQ;
            end
            PH_SEQ: begin
                sequence_next = rx_byte;
                crc_next      = crc_upd;
                phase_next    = PH_LENH;
            end
            PH_LENH: begin
                length_next = {rx_byte, 8'd0};
                crc_next    = crc_upd;
                phase_next  = PH_LENL;
            end
            PH_LENL: begin
                length_next = {length_reg[15:8], rx_byte};
                crc_next    = crc_upd;
                count_next  = 16'd0;
                if (length_next > cfg.length_limit) begin
                    phase_next    = PH_SYNC0;
                    emit          = 1'b1;
                    res.event_res = EV_LEN_LARGE;
                end else if (length_next != 16'd0) begin
                    phase_next = PH_PAYLOAD;
                end else begin
                    phase_next = PH_CRCH;
                end
            end
            PH_PAYLOAD: begin
                crc_next       = crc_upd;
                count_next     = count_inc;
                emit           = 1'b1;
                res.event_res  = EV_PAYLOAD;
                res.data_byte  = rx_byte;
                res.byte_index = count_reg;
                if (count_inc >= length_reg) begin
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH: begin
                crc_high_next = rx_byte;
                phase_next    = PH_CRCL;
            end
            PH_CRCL: begin
                phase_next       = PH_SYNC0;
                emit             = 1'b1;
                res.event_res    = (crc_calc == crc_rx) ? EV_GOOD : EV_CRC_BAD;
                res.crc_received = crc_rx;
                res.crc_computed = crc_calc;
            end
            default: begin
                // hunting, also the way out of any stray phase code
                if (rx_byte == cfg.sync_first) begin
                    crc_next   = crc_upd;
                    phase_next = PH_SYNC1;
                end else begin
                    phase_next = PH_SYNC0;
                end
            end
        endcase

        res.command      = command_next;
        res.sequence_res = sequence_next;
        res.frame_length = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC0;
            command_reg  <= 8'd0;
            sequence_reg <= 8'd0;
            length_reg   <= 16'd0;
            count_reg    <= 16'd0;
            crc_reg      <= CRC_SEED_RESET;
            crc_high_reg <= 8'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            command_reg  <= command_next;
            sequence_reg <= sequence_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
        end
    end

endmodule

[rtl/core/sync_length_crc_frame_receiver_core.sv]
// Frame receiver for a byte stream: hunts for two sync bytes, reads command,
// sequence and a big-endian payload length, passes each payload byte out with
// its index and ends with a good/bad verdict against the big-endian CRC-16
// (reflected, run over sync, header and payload) that trails the frame. A
// length above the limit gives a rejection event and restarts the hunt. One
// byte is taken every clock cycle while the result side keeps up: the byte CRC
// update is unrolled into combinational logic between the input register and
// the result register; a result is offered once its byte has left the input
// register. A byte that gives a result waits only while an earlier result is
// still held. Result kinds on m_tuser: 0 payload byte, 1 frame good, 2 CRC
// mismatch, 3 length too large.
// Registers: 0 sync_first, 1 sync_second, 2 length_limit, 3 crc_polynomial,
// 4 crc_seed; write them only while no frame is in flight.
module sync_length_crc_frame_receiver_core
    import slrx_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // rx_byte

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // data_byte, byte_index, command, sequence_res, frame_length,
    // crc_received, crc_computed
    output logic [87:0]            m_tdata,
    output logic [1:0]             m_tuser,   // event_res

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t       cfg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;
    logic       step;
    logic       emit;
    res_t       res;

    slrx_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    slrx_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .res     (res)
    );

    // a byte that gives no result never waits for the output side
    assign step     = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (step && emit) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {out_res_reg.crc_computed, out_res_reg.crc_received,
                       out_res_reg.frame_length, out_res_reg.sequence_res,
                       out_res_reg.command, out_res_reg.byte_index,
                       out_res_reg.data_byte};

    // input stage only holds back when it is full
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stage stalled while empty");

    // verdict agrees with the two crc fields it carries
    a_verdict_match : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_GOOD || m_tuser == EV_CRC_BAD)) |->
        ((m_tuser == EV_GOOD) == (m_tdata[71:56] == m_tdata[87:72])))
        else $error("frame verdict disagrees with crc fields");

    // only payload events carry a data byte and index
    a_non_payload_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_PAYLOAD) |-> (m_tdata[23:0] == 24'd0))
        else $error("non-payload event with data or index set");

endmodule
